FILE: rtl/dlr_pkg.sv
// shared types and constants of the dashed line rasterizer
package dlr_pkg;

  localparam int unsigned IN_COORD_W  = 12;
  localparam int unsigned OUT_COORD_W = 12;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned PHASE_W     = 7;
  localparam int unsigned IN_DATA_W   = 56;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [LEN_W-1:0] DASH_LEN_RESET = 6'd10;

  typedef enum logic [1:0] {
    FUNC_BEGIN   = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic dashed;
    logic clr;
  } step_flags_t;

endpackage

FILE: rtl/dlr_step.sv
// line walker: endpoint load, error term update and pixel stepping
module dlr_step import dlr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  func_t                        func,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         dashed,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output step_flags_t                  flags
);

  localparam int unsigned EW = COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt;
  logic        [COORD_BITS-1:0] maj_r, min_r;
  logic signed [EW-1:0]         err_r;
  logic        [1:0]            dir_r;
  logic                         x_major_r, dashed_r, busy_r;

  logic signed [COORD_BITS:0]   dx, dy;
  logic        [COORD_BITS:0]   ax_w, ay_w;
  logic        [COORD_BITS-1:0] ax, ay, maj_b, min_b;
  logic                         x_major_b, busy_b;

  logic signed [EW-1:0]         e1, e2;
  logic                         step_min, done;
  logic        [COORD_BITS-1:0] xinc, yinc;

  // begin: deltas and axis choice
  always_comb begin
    dx        = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy        = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    ax_w      = dx[COORD_BITS] ? -dx : dx;
    ay_w      = dy[COORD_BITS] ? -dy : dy;
    ax        = ax_w[COORD_BITS-1:0];
    ay        = ay_w[COORD_BITS-1:0];
    x_major_b = (ay <= ax);
    maj_b     = x_major_b ? ax : ay;
    min_b     = x_major_b ? ay : ax;
    busy_b    = (maj_b != '0);
  end

  // advance: one error update and one step
  always_comb begin
    e1        = err_r + {2'b00, min_r};
    step_min  = !e1[EW-1] && (e1 != '0);
    e2        = step_min ? (e1 - {2'b00, maj_r}) : e1;
    xinc      = dir_r[0] ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    yinc      = dir_r[1] ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    cur_x_nxt = (x_major_r || step_min) ? (cur_x_r + xinc) : cur_x_r;
    cur_y_nxt = (!x_major_r || step_min) ? (cur_y_r + yinc) : cur_y_r;
    done      = x_major_r ? (cur_x_nxt == tgt_x_r) : (cur_y_nxt == tgt_y_r);
  end

  always_comb begin
    flags   = '0;
    pixel_x = cur_x_nxt;
    pixel_y = cur_y_nxt;
    case (func)
      FUNC_BEGIN: begin
        pixel_x      = start_x;
        pixel_y      = start_y;
        flags.emit   = go;
        flags.last   = !busy_b;
        flags.dashed = dashed;
      end
      FUNC_ADVANCE: begin
        flags.emit   = go && busy_r;
        flags.last   = done;
        flags.dashed = dashed_r;
      end
      FUNC_CLEAR: begin
        flags.clr = go;
      end
      default: begin
        flags = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      tgt_x_r   <= '0;
      tgt_y_r   <= '0;
      maj_r     <= '0;
      min_r     <= '0;
      err_r     <= '0;
      dir_r     <= '0;
      x_major_r <= 1'b0;
      dashed_r  <= 1'b0;
      busy_r    <= 1'b0;
    end else if (go) begin
      case (func)
        FUNC_BEGIN: begin
          cur_x_r   <= start_x;
          cur_y_r   <= start_y;
          tgt_x_r   <= end_x;
          tgt_y_r   <= end_y;
          maj_r     <= maj_b;
          min_r     <= min_b;
          err_r     <= '0;
          dir_r     <= {dy[COORD_BITS], dx[COORD_BITS]};
          x_major_r <= x_major_b;
          dashed_r  <= dashed;
          busy_r    <= busy_b;
        end
        FUNC_ADVANCE: begin
          if (busy_r) begin
            cur_x_r <= cur_x_nxt;
            cur_y_r <= cur_y_nxt;
            err_r   <= e2;
            busy_r  <= !done;
          end
        end
        default: begin
          busy_r <= busy_r;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dlr_dash.sv
// dash length register, dash phase counter and lit decision
module dlr_dash import dlr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_len,
  input  step_flags_t      flags,
  output logic             lit,
  output logic             hold
);

  localparam int unsigned IDX_W = $clog2(PHASE_W);

  logic [LEN_W-1:0]   len_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LEN_W-1:0]   len_eff;
  logic [PHASE_W:0]   inc;
  logic               q0;

  // serial divide of the phase by a newly written length
  logic               div_busy_r;
  logic [IDX_W-1:0]   div_idx_r;
  logic [LEN_W-1:0]   div_rem_r, div_rem_nxt;
  logic               div_q_r;
  logic [LEN_W:0]     div_sh, div_diff;
  logic               div_ge;

  always_comb begin
    len_eff     = (len_r == '0) ? LEN_W'(1) : len_r;
    div_sh      = {div_rem_r, phase_r[div_idx_r]};
    div_diff    = div_sh - {1'b0, len_eff};
    div_ge      = (div_sh >= {1'b0, len_eff});
    div_rem_nxt = div_ge ? div_diff[LEN_W-1:0] : div_sh[LEN_W-1:0];
    // past twice the length only right after a shorter length is written
    if (phase_r >= {len_eff, 1'b0}) begin
      q0 = div_q_r;
    end else begin
      q0 = (phase_r >= {1'b0, len_eff});
    end
    lit       = !flags.dashed || q0;
    inc       = {1'b0, phase_r} + (PHASE_W+1)'(1);
    phase_nxt = (inc >= {1'b0, len_eff, 1'b0}) ? '0 : inc[PHASE_W-1:0];
  end

  assign hold = div_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= DASH_LEN_RESET;
      phase_r    <= '0;
      div_busy_r <= 1'b0;
      div_idx_r  <= '0;
      div_rem_r  <= '0;
      div_q_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r      <= cfg_len;
        div_busy_r <= 1'b1;
        div_idx_r  <= IDX_W'(PHASE_W - 1);
        div_rem_r  <= '0;
      end else if (div_busy_r) begin
        div_rem_r <= div_rem_nxt;
        div_q_r   <= div_ge;
        if (div_idx_r == '0) begin
          div_busy_r <= 1'b0;
        end else begin
          div_idx_r <= div_idx_r - IDX_W'(1);
        end
      end
      if (flags.clr) begin
        phase_r <= '0;
      end else if (flags.emit) begin
        phase_r <= phase_nxt;
      end
    end
  end

endmodule

FILE: rtl/dashed_line_rasterizer_top.sv
// Dashed line rasterizer: input register, line walker, dash gate and result register.
// The walker acts on each operation as it leaves the input register, so a new operation
// is accepted every clock while results are taken; a pixel goes from the input register
// through walker and dash gate into the result register. The input register stalls while
// a finished pixel waits in the result register, and after a dash length write while the
// dash phase is divided by the new length one quotient bit per cycle. Begin and advance
// give one pixel each (advance gives none after the end pixel); reset dash gives none.
// Write the dash length only while no operation is in flight.
module dashed_line_rasterizer_top import dlr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, end_x, end_y, dashed, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_x, pixel_y, lit, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_data
);

  logic                  in_valid_r;
  logic [1:0]            in_func_r;
  logic [IN_COORD_W-1:0] in_sx_r, in_sy_r, in_ex_r, in_ey_r;
  logic                  in_dashed_r;
  logic                  go;

  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, px, py;
  logic [OUT_COORD_W-1:0]       px12, py12;
  step_flags_t                  flags;
  logic                         lit;
  logic                         dash_hold;

  logic                   out_valid_r;
  logic [OUT_COORD_W-1:0] out_x_r, out_y_r;
  logic                   out_lit_r, out_last_r;

  assign go        = in_valid_r && !dash_hold && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_func_r   <= in_tuser;
      in_sx_r     <= in_tdata[11:0];
      in_sy_r     <= in_tdata[23:12];
      in_ex_r     <= in_tdata[35:24];
      in_ey_r     <= in_tdata[47:36];
      in_dashed_r <= in_tdata[48];
    end
  end

  generate
    if (COORD_BITS <= IN_COORD_W) begin : g_in_narrow
      assign sx = in_sx_r[COORD_BITS-1:0];
      assign sy = in_sy_r[COORD_BITS-1:0];
      assign ex = in_ex_r[COORD_BITS-1:0];
      assign ey = in_ey_r[COORD_BITS-1:0];
    end else begin : g_in_wide
      assign sx = {{(COORD_BITS-IN_COORD_W){in_sx_r[IN_COORD_W-1]}}, in_sx_r};
      assign sy = {{(COORD_BITS-IN_COORD_W){in_sy_r[IN_COORD_W-1]}}, in_sy_r};
      assign ex = {{(COORD_BITS-IN_COORD_W){in_ex_r[IN_COORD_W-1]}}, in_ex_r};
      assign ey = {{(COORD_BITS-IN_COORD_W){in_ey_r[IN_COORD_W-1]}}, in_ey_r};
    end
    if (COORD_BITS >= OUT_COORD_W) begin : g_out_wide
      assign px12 = px[OUT_COORD_W-1:0];
      assign py12 = py[OUT_COORD_W-1:0];
    end else begin : g_out_narrow
      assign px12 = {{(OUT_COORD_W-COORD_BITS){px[COORD_BITS-1]}}, px};
      assign py12 = {{(OUT_COORD_W-COORD_BITS){py[COORD_BITS-1]}}, py};
    end
  endgenerate

  dlr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .func    (func_t'(in_func_r)),
    .start_x (sx),
    .start_y (sy),
    .end_x   (ex),
    .end_y   (ey),
    .dashed  (in_dashed_r),
    .pixel_x (px),
    .pixel_y (py),
    .flags   (flags)
  );

  dlr_dash u_dash (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_len (cfg_data),
    .flags   (flags),
    .lit     (lit),
    .hold    (dash_hold)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= flags.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && flags.emit) begin
      out_x_r    <= px12;
      out_y_r    <= py12;
      out_lit_r  <= lit;
      out_last_r <= flags.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_lit_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/dlr_checker.sv
// port checks for the dashed line rasterizer and their bind
module dlr_checker import dlr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // an offered result carries known data
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tlast, in_tready}))
    else $error("unknown value on an offered result");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind dashed_line_rasterizer_top dlr_checker u_dlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

FILE: dv/tb.sv
// self-checking testbench for the dashed line rasterizer: line walks, dash gate, handshakes
module tb;
  import dlr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] x;
    logic [OUT_COORD_W-1:0] y;
    logic                   lit;
    logic                   is_end;
  } pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LEN_W-1:0]      cfg_data;

  // walker copy kept by the testbench
  int         walk_x, walk_y, goal_x, goal_y;
  int         major_d, minor_d, err_acc;
  bit         x_back, y_back, major_is_x, dash_on, line_active;
  int         phase_cnt;
  logic [5:0] dash_len_cfg;

  pixel_t expected_pixels[$];
  int     gap_pct;
  int     stall_pct;
  int     errors;
  int     pixels_checked;
  int     ops_effective;
  int     settings_written;

  dashed_line_rasterizer_top #(.COORD_BITS(12)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int rand_coord();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  function automatic int near_coord(int c, int span);
    int d;
    int e;
    d = int'($urandom_range(2 * span)) - span;
    e = c + d;
    if (e > 2047 || e < -2048) e = c - d;
    return e;
  endfunction

  function automatic void push_pixel(int x, int y, bit is_end);
    int     len;
    int     p;
    pixel_t px;
    len = (dash_len_cfg == 0) ? 1 : int'(dash_len_cfg);
    px.x = x[OUT_COORD_W-1:0];
    px.y = y[OUT_COORD_W-1:0];
    px.lit = !dash_on || (((phase_cnt / len) & 1) == 1);
    px.is_end = is_end;
    p = phase_cnt + 1;
    phase_cnt = (p >= 2 * len) ? 0 : (p & 8'h7f);
    expected_pixels = {expected_pixels, px};
  endfunction

  function automatic void apply_op(logic [1:0] op, int sx, int sy, int ex, int ey, bit dsh);
    int  dx, dy, ax, ay;
    bit  done;
    case (op)
      FUNC_BEGIN: begin
        walk_x = sx;
        walk_y = sy;
        goal_x = ex;
        goal_y = ey;
        dash_on = dsh;
        dx = goal_x - walk_x;
        dy = goal_y - walk_y;
        x_back = dx < 0;
        y_back = dy < 0;
        ax = x_back ? -dx : dx;
        ay = y_back ? -dy : dy;
        major_is_x = ay <= ax;
        major_d = major_is_x ? ax : ay;
        minor_d = major_is_x ? ay : ax;
        err_acc = 0;
        line_active = major_d != 0;
        ops_effective++;
        push_pixel(walk_x, walk_y, !line_active);
      end
      FUNC_ADVANCE: begin
        if (line_active) begin
          err_acc += minor_d;
          if (err_acc > 0) begin
            err_acc -= major_d;
            if (major_is_x) walk_y += y_back ? -1 : 1;
            else walk_x += x_back ? -1 : 1;
          end
          if (major_is_x) walk_x += x_back ? -1 : 1;
          else walk_y += y_back ? -1 : 1;
          done = major_is_x ? (walk_x == goal_x) : (walk_y == goal_y);
          if (done) line_active = 1'b0;
          ops_effective++;
          push_pixel(walk_x, walk_y, done);
        end
      end
      FUNC_CLEAR: begin
        phase_cnt = 0;
        ops_effective++;
      end
      default: ;
    endcase
  endfunction

  // leaves tvalid high after the transfer; the next negedge lowers it or presents a new item
  task automatic send_op(logic [1:0] op, int sx, int sy, int ex, int ey, bit dsh);
    @(negedge clk);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, dsh, ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
    do @(posedge clk); while (!in_tready);
    apply_op(op, sx, sy, ex, ey, dsh);
  endtask

  task automatic send_noise(logic [1:0] op);
    send_op(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
  endtask

  task automatic walk_line(int sx, int sy, int ex, int ey, bit dsh, int steps);
    send_op(FUNC_BEGIN, sx, sy, ex, ey, dsh);
    repeat (steps) send_op(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dash_length(logic [5:0] len);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    dash_len_cfg = len;
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_ignored_ops();
    send_op(FUNC_ADVANCE, 5, 6, 7, 8, 1'b1);
    send_op(FUNC_UNUSED, -1, -1, -1, -1, 1'b1);
    send_op(FUNC_BEGIN, -2048, -2048, -2048, -2048, 1'b1);
    send_op(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_line_shapes();
    walk_line(2047, 2047, 2044, 2047, 1'b1, 3);
    send_op(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0);
    walk_line(0, 0, 0, 3, 1'b0, 3);
    walk_line(5, -5, 2, -1, 1'b1, 4);
    walk_line(3, 3, 5, 5, 1'b0, 2);
    // new line dropped part way, dash phase cleared under a live line
    walk_line(-2048, 2047, 2047, -2048, 1'b1, 2);
    send_op(FUNC_CLEAR, 0, 0, 0, 0, 1'b0);
    send_op(FUNC_ADVANCE, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_dash_lengths();
    write_dash_length(6'd0);
    walk_line(0, 0, 4, 1, 1'b1, 4);
    write_dash_length(6'd63);
    walk_line(0, 0, 70, 0, 1'b1, 70);
    // shorter length while the phase sits past the new wrap point
    write_dash_length(6'd3);
    walk_line(0, 0, -5, 2, 1'b1, 5);
  endtask

  task automatic test_random_traffic(int n_ops, int gap, int stall, logic [5:0] len);
    int target, r, span, sx, sy, ex, ey, cap, k;
    write_dash_length(len);
    gap_pct = gap;
    stall_pct = stall;
    target = ops_effective + n_ops;
    while (ops_effective < target) begin
      if ($urandom_range(99) < 85) begin
        r = $urandom_range(99);
        span = (r < 85) ? 24 : (r < 95) ? 120 : 0;
        sx = rand_coord();
        sy = rand_coord();
        if (span == 0) begin
          ex = rand_coord();
          ey = rand_coord();
        end else begin
          ex = near_coord(sx, span);
          ey = near_coord(sy, span);
        end
        r = $urandom_range(99);
        if (r < 4) ex = sx;
        else if (r < 8) ey = sy;
        else if (r < 11) begin
          ex = sx;
          ey = sy;
        end
        cap = (span == 0 || $urandom_range(99) < 10) ? int'($urandom_range(1, 40)) : 100000;
        send_op(FUNC_BEGIN, sx, sy, ex, ey, 1'($urandom_range(1)));
        k = 0;
        while (line_active && k < cap) begin
          r = $urandom_range(99);
          if (r < 3) send_noise(FUNC_CLEAR);
          else if (r < 5) send_noise(FUNC_UNUSED);
          else begin
            send_noise(FUNC_ADVANCE);
            k++;
          end
        end
        if ($urandom_range(99) < 25) send_noise(FUNC_ADVANCE);
      end else begin
        send_noise(2'($urandom_range(3)));
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with nothing expected: x=%0d y=%0d",
               $signed(out_tdata[11:0]), $signed(out_tdata[23:12]));
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_tdata[11:0] !== want.x) begin
          $error("pixel_x expected %0d got %0d", $signed(want.x), $signed(out_tdata[11:0]));
          errors++;
        end
        if (out_tdata[23:12] !== want.y) begin
          $error("pixel_y expected %0d got %0d", $signed(want.y), $signed(out_tdata[23:12]));
          errors++;
        end
        if (out_tdata[24] !== want.lit) begin
          $error("lit expected %0b got %0b", want.lit, out_tdata[24]);
          errors++;
        end
        if (out_tlast !== want.is_end) begin
          $error("last expected %0b got %0b", want.is_end, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_ADVANCE;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = DASH_LEN_RESET;
    dash_len_cfg = DASH_LEN_RESET;
    walk_x = 0; walk_y = 0; goal_x = 0; goal_y = 0;
    major_d = 0; minor_d = 0; err_acc = 0;
    x_back = 0; y_back = 0; major_is_x = 0; dash_on = 0; line_active = 0;
    phase_cnt = 0;
    gap_pct = 0;
    stall_pct = 0;
    errors = 0;
    pixels_checked = 0;
    ops_effective = 0;
    settings_written = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_ops();
    test_line_shapes();
    test_dash_lengths();
    test_random_traffic(450, 0, 0, 6'd63);
    test_random_traffic(450, 63, 0, 6'd1);
    test_random_traffic(450, 0, 63, 6'($urandom_range(2, 62)));
    test_random_traffic(450, 25, 25, 6'd5);
    wait_quiet();

    $display("%0d operations took effect, %0d pixels checked against the walker copy",
             ops_effective, pixels_checked);
    $display("dash length written %0d times incl. 0, 1 and 63, under four pressure phases",
             settings_written);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dlr_pkg.sv
rtl/dlr_step.sv
rtl/dlr_dash.sv
rtl/dashed_line_rasterizer_top.sv
rtl/dlr_checker.sv
dv/tb.sv
